// File: sv/baro_pressure_temp_compensation_assert.svh
// Assertion macros for the pressure/temperature compensation block.
// Used by the top level only; relies on aclk and aresetn being in scope.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define BPTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define BPTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bptc_pkg.sv
// Shared widths, constants, stage payload types and saturation helper
// for the pressure/temperature compensation pipeline. No dependencies.
package bptc_pkg;

    localparam int RAW_W     = 24;  // raw conversion counts
    localparam int CAL_W     = 16;  // calibration words
    localparam int CFG_IDX_W = 3;
    localparam int DT_W      = 25;  // raw_temperature - c5*256
    localparam int PROD_W    = 42;  // dT times a calibration word
    localparam int DTSQ_W    = 50;  // dT squared
    localparam int TEMP_W    = 21;  // temperature, hundredths of a degree
    localparam int T2_W      = 19;  // dT^2 / 2^31
    localparam int WIDE_W    = 40;  // OFF, SENS and their corrections
    localparam int SPLIT_W   = 20;  // low slice of SENS for the split multiply
    localparam int PPL_W     = RAW_W + SPLIT_W;          // 44
    localparam int PPH_W     = RAW_W + 1 + WIDE_W - SPLIT_W; // 45
    localparam int FULL_W    = 64;
    localparam int SAT_IN_W  = 48;
    localparam int OUT_W     = 32;

    localparam int SH_C5   = 8;
    localparam int SH_C2   = 16;
    localparam int SH_C1   = 15;
    localparam int SH_T    = 23;
    localparam int SH_OFF  = 7;
    localparam int SH_SENS = 8;
    localparam int SH_T2   = 31;
    localparam int SH_P1   = 21;
    localparam int SH_P2   = 15;

    localparam logic signed [TEMP_W-1:0] TEMP_REF   = TEMP_W'(2000);
    localparam logic signed [TEMP_W-1:0] TEMP_VCOLD = TEMP_W'(1500);

    // Calibration register indexes
    localparam logic [CFG_IDX_W-1:0] CAL_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CAL_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CAL_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CAL_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CAL_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CAL_C6 = 3'd5;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } cal_t;

    // First-order results
    typedef struct packed {
        logic [RAW_W-1:0]         raw_pressure;
        logic signed [TEMP_W-1:0] temp;
        logic [T2_W-1:0]          t2;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
    } front_t;

    // Second-order corrected results
    typedef struct packed {
        logic [RAW_W-1:0]         raw_pressure;
        logic signed [TEMP_W-1:0] temp;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
    } corr_t;

    function automatic logic [OUT_W-1:0] sat_s32(input logic signed [SAT_IN_W-1:0] v);
        logic [OUT_W-1:0] r;
        if ((&v[SAT_IN_W-1:OUT_W-1]) || !(|v[SAT_IN_W-1:OUT_W-1])) begin
            r = v[OUT_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: sv/baro_pressure_temp_compensation.sv
// Top level of the barometric pressure/temperature compensation pipeline.
// Depends on bptc_pkg, bptc_front, bptc_corr, bptc_pres and the assertion header.

// Turns a raw 24-bit pressure count and a raw 24-bit temperature count into
// temperature in hundredths of a degree Celsius and pressure in pascals, using
// six 16-bit calibration words written through the cfg_ port (index 0..5 for
// c1..c6; indexes 6 and 7 are ignored; all words reset to zero). Below 20.00
// degrees a second-order correction applies, with an extra term below -15.00
// degrees; both outputs saturate to signed 32 bits. The block is a ten-stage
// pipeline: one word enters per cycle while the output side does not stall,
// and its result reaches m_tdata once it has passed through every stage.
// Each stage holds its word only while the stage after it is full and cannot
// pass its own word on, so empty slots keep taking input even while a
// finished result waits at m_tdata. Write calibration only while no word is
// in flight.
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    // Calibration write port
    input  logic        cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bptc_pkg::CAL_W-1:0]     cfg_wdata,
    // Raw sample pair
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    // Compensated result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] temperature_centi, [63:32] pressure_pa
);

    bptc_pkg::cal_t   cal_reg;

    logic             front_valid, front_ready;
    bptc_pkg::front_t front_data;
    logic             corr_valid, corr_ready;
    bptc_pkg::corr_t  corr_data;

    logic [bptc_pkg::OUT_W-1:0] temperature_centi;
    logic [bptc_pkg::OUT_W-1:0] pressure_pa;

    // Calibration words; a write to an unused index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                bptc_pkg::CAL_C1: cal_reg.c1 <= cfg_wdata;
                bptc_pkg::CAL_C2: cal_reg.c2 <= cfg_wdata;
                bptc_pkg::CAL_C3: cal_reg.c3 <= cfg_wdata;
                bptc_pkg::CAL_C4: cal_reg.c4 <= cfg_wdata;
                bptc_pkg::CAL_C5: cal_reg.c5 <= cfg_wdata;
                bptc_pkg::CAL_C6: cal_reg.c6 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stages 1-3: dT, products, first-order TEMP/OFF/SENS
    bptc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cal             (cal_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .raw_pressure    (s_tdata[23:0]),
        .raw_temperature (s_tdata[47:24]),
        .out_valid       (front_valid),
        .out_ready       (front_ready),
        .out_data        (front_data)
    );

    // Stages 4-7: cold and very-cold corrections
    bptc_corr u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_data  (corr_data)
    );

    // Stages 8-10: pressure product, offset, saturation; last stage is the
    // output register
    bptc_pres u_pres (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (corr_valid),
        .in_ready          (corr_ready),
        .in_data           (corr_data),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .temperature_centi (temperature_centi),
        .pressure_pa       (pressure_pa)
    );

    assign m_tdata = {pressure_pa, temperature_centi};

    // Input backs up only when every stage is full and the output is stalled
    `BPTC_ASSERT_NOW(a_full_stall, !s_tready, m_tvalid && !m_tready, "input stalled with room in pipe")
    // No result word right after reset
    `BPTC_ASSERT_NEXT(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")
    // Compensated temperature always fits in 20 signed bits, never saturates
    `BPTC_ASSERT_NOW(a_temp_range, m_tvalid, m_tdata[31:20] == {12{m_tdata[19]}}, "temperature out of range")

endmodule

// File: sv/bptc_front.sv
// First-order stages: dT, the four dT products, then TEMP, OFF, SENS and T2.
// Depends on bptc_pkg.
module bptc_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bptc_pkg::cal_t         cal,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [bptc_pkg::RAW_W-1:0] raw_pressure,
    input  logic [bptc_pkg::RAW_W-1:0] raw_temperature,
    output logic                   out_valid,
    input  logic                   out_ready,
    output bptc_pkg::front_t       out_data
);

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic s1_rdy, s2_rdy, s3_rdy;

    logic [bptc_pkg::RAW_W-1:0]         d1_s1_reg, d1_s2_reg;
    logic signed [bptc_pkg::DT_W-1:0]   dt_reg, dt_next;
    logic signed [bptc_pkg::PROD_W-1:0] p6_reg, p6_next;
    logic signed [bptc_pkg::PROD_W-1:0] p4_reg, p4_next;
    logic signed [bptc_pkg::PROD_W-1:0] p3_reg, p3_next;
    logic signed [bptc_pkg::DTSQ_W-1:0] dtsq_reg, dtsq_next;
    bptc_pkg::front_t                   s3_reg, s3_next;

    // Pass a stage when it is empty or its successor takes the word
    assign s3_rdy   = !s3_vld_reg || out_ready;
    assign s2_rdy   = !s2_vld_reg || s3_rdy;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign in_ready = s1_rdy;

    always_comb begin
        dt_next = $signed({1'b0, raw_temperature})
                - $signed({1'b0, cal.c5, {bptc_pkg::SH_C5{1'b0}}});
    end

    always_comb begin
        p6_next   = bptc_pkg::PROD_W'(dt_reg) * bptc_pkg::PROD_W'($signed({1'b0, cal.c6}));
        p4_next   = bptc_pkg::PROD_W'(dt_reg) * bptc_pkg::PROD_W'($signed({1'b0, cal.c4}));
        p3_next   = bptc_pkg::PROD_W'(dt_reg) * bptc_pkg::PROD_W'($signed({1'b0, cal.c3}));
        dtsq_next = bptc_pkg::DTSQ_W'(dt_reg) * bptc_pkg::DTSQ_W'(dt_reg);
    end

    always_comb begin
        s3_next.raw_pressure = d1_s2_reg;
        s3_next.temp = bptc_pkg::TEMP_W'(p6_reg >>> bptc_pkg::SH_T) + bptc_pkg::TEMP_REF;
        // dT squared is never negative: a plain slice is the shift
        s3_next.t2   = dtsq_reg[bptc_pkg::SH_T2 +: bptc_pkg::T2_W];
        s3_next.off  = bptc_pkg::WIDE_W'($signed({1'b0, cal.c2, {bptc_pkg::SH_C2{1'b0}}}))
                     + bptc_pkg::WIDE_W'(p4_reg >>> bptc_pkg::SH_OFF);
        s3_next.sens = bptc_pkg::WIDE_W'($signed({1'b0, cal.c1, {bptc_pkg::SH_C1{1'b0}}}))
                     + bptc_pkg::WIDE_W'(p3_reg >>> bptc_pkg::SH_SENS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            if (s1_rdy) s1_vld_reg <= in_valid;
            if (s2_rdy) s2_vld_reg <= s1_vld_reg;
            if (s3_rdy) s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy && in_valid) begin
            d1_s1_reg <= raw_pressure;
            dt_reg    <= dt_next;
        end
        if (s2_rdy && s1_vld_reg) begin
            d1_s2_reg <= d1_s1_reg;
            p6_reg    <= p6_next;
            p4_reg    <= p4_next;
            p3_reg    <= p3_next;
            dtsq_reg  <= dtsq_next;
        end
        if (s3_rdy && s2_vld_reg) begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_vld_reg;
    assign out_data  = s3_reg;

endmodule

// File: sv/bptc_corr.sv
// Second-order correction stages: cold and very-cold terms applied to
// TEMP, OFF and SENS. Depends on bptc_pkg.
module bptc_corr (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  bptc_pkg::front_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output bptc_pkg::corr_t  out_data
);

    logic s4_vld_reg, s5_vld_reg, s6_vld_reg, s7_vld_reg;
    logic s4_rdy, s5_rdy, s6_rdy, s7_rdy;

    // Stage 4: distances from the two thresholds
    bptc_pkg::front_t                   f4_reg;
    logic signed [bptc_pkg::TEMP_W-1:0] a_reg, a_next;
    logic signed [bptc_pkg::TEMP_W-1:0] b_reg, b_next;
    logic                               cold4_reg, vcold4_reg;

    // Stage 5: squares
    bptc_pkg::front_t                   f5_reg;
    logic signed [bptc_pkg::WIDE_W-1:0] aa_reg, aa_next;
    logic signed [bptc_pkg::WIDE_W-1:0] bb_reg, bb_next;
    logic                               cold5_reg, vcold5_reg;

    // Stage 6: correction terms and corrected temperature
    logic [bptc_pkg::RAW_W-1:0]         d1_s6_reg;
    logic signed [bptc_pkg::TEMP_W-1:0] temp6_reg, temp6_next;
    logic signed [bptc_pkg::WIDE_W-1:0] off6_reg, sens6_reg;
    logic signed [bptc_pkg::WIDE_W-1:0] off2_reg, off2_next;
    logic signed [bptc_pkg::WIDE_W-1:0] sens2_reg, sens2_next;

    bptc_pkg::corr_t                    s7_reg, s7_next;

    assign s7_rdy   = !s7_vld_reg || out_ready;
    assign s6_rdy   = !s6_vld_reg || s7_rdy;
    assign s5_rdy   = !s5_vld_reg || s6_rdy;
    assign s4_rdy   = !s4_vld_reg || s5_rdy;
    assign in_ready = s4_rdy;

    always_comb begin
        a_next = in_data.temp - bptc_pkg::TEMP_REF;
        b_next = in_data.temp + bptc_pkg::TEMP_VCOLD;
    end

    always_comb begin
        aa_next = bptc_pkg::WIDE_W'(a_reg) * bptc_pkg::WIDE_W'(a_reg);
        bb_next = bptc_pkg::WIDE_W'(b_reg) * bptc_pkg::WIDE_W'(b_reg);
    end

    always_comb begin
        logic signed [bptc_pkg::WIDE_W-1:0] sq5;
        logic signed [bptc_pkg::WIDE_W-1:0] bb7;
        logic signed [bptc_pkg::WIDE_W-1:0] bb11;
        sq5  = (aa_reg <<< 2) + aa_reg;
        bb7  = (bb_reg <<< 3) - bb_reg;
        bb11 = (bb_reg <<< 3) + (bb_reg <<< 1) + bb_reg;
        off2_next  = '0;
        sens2_next = '0;
        temp6_next = f5_reg.temp;
        if (cold5_reg) begin
            off2_next  = sq5 >>> 1;
            sens2_next = sq5 >>> 2;
            temp6_next = f5_reg.temp - $signed({2'b00, f5_reg.t2});
            if (vcold5_reg) begin
                off2_next  = (sq5 >>> 1) + bb7;
                sens2_next = (sq5 >>> 2) + (bb11 >>> 1);
            end
        end
    end

    always_comb begin
        s7_next.raw_pressure = d1_s6_reg;
        s7_next.temp         = temp6_reg;
        s7_next.off          = off6_reg - off2_reg;
        s7_next.sens         = sens6_reg - sens2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end else begin
            if (s4_rdy) s4_vld_reg <= in_valid;
            if (s5_rdy) s5_vld_reg <= s4_vld_reg;
            if (s6_rdy) s6_vld_reg <= s5_vld_reg;
            if (s7_rdy) s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_rdy && in_valid) begin
            f4_reg     <= in_data;
            a_reg      <= a_next;
            b_reg      <= b_next;
            cold4_reg  <= a_next[bptc_pkg::TEMP_W-1];
            vcold4_reg <= b_next[bptc_pkg::TEMP_W-1];
        end
        if (s5_rdy && s4_vld_reg) begin
            f5_reg     <= f4_reg;
            aa_reg     <= aa_next;
            bb_reg     <= bb_next;
            cold5_reg  <= cold4_reg;
            vcold5_reg <= vcold4_reg;
        end
        if (s6_rdy && s5_vld_reg) begin
            d1_s6_reg <= f5_reg.raw_pressure;
            temp6_reg <= temp6_next;
            off6_reg  <= f5_reg.off;
            sens6_reg <= f5_reg.sens;
            off2_reg  <= off2_next;
            sens2_reg <= sens2_next;
        end
        if (s7_rdy && s6_vld_reg) begin
            s7_reg <= s7_next;
        end
    end

    assign out_valid = s7_vld_reg;
    assign out_data  = s7_reg;

endmodule

// File: sv/bptc_pres.sv
// Pressure stages: raw_pressure * SENS as two partial products, their sum,
// then the offset, final shift and saturation. Depends on bptc_pkg.
module bptc_pres (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bptc_pkg::corr_t            in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bptc_pkg::OUT_W-1:0] temperature_centi,
    output logic [bptc_pkg::OUT_W-1:0] pressure_pa
);

    logic s8_vld_reg, s9_vld_reg, s10_vld_reg;
    logic s8_rdy, s9_rdy, s10_rdy;

    logic [bptc_pkg::PPL_W-1:0]         pp_lo_reg, pp_lo_next;
    logic signed [bptc_pkg::PPH_W-1:0]  pp_hi_reg, pp_hi_next;
    logic signed [bptc_pkg::FULL_W-1:0] prod_reg, prod_next;
    logic signed [bptc_pkg::TEMP_W-1:0] temp8_reg, temp9_reg;
    logic signed [bptc_pkg::WIDE_W-1:0] off8_reg, off9_reg;
    logic [bptc_pkg::OUT_W-1:0]         tc_reg, tc_next;
    logic [bptc_pkg::OUT_W-1:0]         pa_reg, pa_next;

    assign s10_rdy  = !s10_vld_reg || out_ready;
    assign s9_rdy   = !s9_vld_reg || s10_rdy;
    assign s8_rdy   = !s8_vld_reg || s9_rdy;
    assign in_ready = s8_rdy;

    // SENS = hi * 2^SPLIT_W + lo, hi signed and lo unsigned
    always_comb begin
        pp_lo_next = bptc_pkg::PPL_W'(in_data.raw_pressure)
                   * bptc_pkg::PPL_W'(in_data.sens[bptc_pkg::SPLIT_W-1:0]);
        pp_hi_next = bptc_pkg::PPH_W'($signed({1'b0, in_data.raw_pressure}))
                   * bptc_pkg::PPH_W'($signed(in_data.sens[bptc_pkg::WIDE_W-1:bptc_pkg::SPLIT_W]));
    end

    always_comb begin
        prod_next = (bptc_pkg::FULL_W'(pp_hi_reg) <<< bptc_pkg::SPLIT_W)
                  + $signed(bptc_pkg::FULL_W'(pp_lo_reg));
    end

    always_comb begin
        logic signed [bptc_pkg::SAT_IN_W-1:0] x;
        x = bptc_pkg::SAT_IN_W'(prod_reg >>> bptc_pkg::SH_P1)
          - bptc_pkg::SAT_IN_W'(off9_reg);
        pa_next = bptc_pkg::sat_s32(x >>> bptc_pkg::SH_P2);
        tc_next = bptc_pkg::sat_s32(bptc_pkg::SAT_IN_W'(temp9_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
        end else begin
            if (s8_rdy)  s8_vld_reg  <= in_valid;
            if (s9_rdy)  s9_vld_reg  <= s8_vld_reg;
            if (s10_rdy) s10_vld_reg <= s9_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s8_rdy && in_valid) begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            temp8_reg <= in_data.temp;
            off8_reg  <= in_data.off;
        end
        if (s9_rdy && s8_vld_reg) begin
            prod_reg  <= prod_next;
            temp9_reg <= temp8_reg;
            off9_reg  <= off8_reg;
        end
        if (s10_rdy && s9_vld_reg) begin
            tc_reg <= tc_next;
            pa_reg <= pa_next;
        end
    end

    assign out_valid         = s10_vld_reg;
    assign temperature_centi = tc_reg;
    assign pressure_pa       = pa_reg;

endmodule
